### hdl/rrdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rrdt_pkg
// Shared widths, constants and types of the recent reading dedup table.
// -----------------------------------------------------------------------------
package rrdt_pkg;

  localparam int unsigned TableEntriesDefault = 32;

  localparam int unsigned DeviceW = 64;
  localparam int unsigned CountW  = 32;
  localparam int unsigned TimeW   = 63;
  localparam int unsigned TtlW    = 32;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [TtlW-1:0] TtlReset = 32'd60000000;

  // register index, taken from paddr[2]
  localparam logic RegTimeToLive = 1'b0;

  typedef struct packed {
    logic               valid;
    logic [DeviceW-1:0] device;
    logic [CountW-1:0]  count;
    logic [TimeW-1:0]   stamp;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctrl_t;

  typedef struct packed {
    logic hit;
    logic expire;
  } probe_t;

endpackage
`default_nettype wire

### hdl/rrdt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rrdt_cell
// One table slot of the ring: takes its neighbour's entry on a shift, or a
// new reading on a write.
// -----------------------------------------------------------------------------
module rrdt_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rrdt_pkg::cell_ctrl_t ctrl_i,
  input  wire rrdt_pkg::entry_t   shift_entry_i,
  input  wire rrdt_pkg::entry_t   wr_entry_i,
  output rrdt_pkg::entry_t        entry_o
);

  logic             valid_q, valid_d;
  rrdt_pkg::entry_t data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.write) begin
      valid_d = wr_entry_i.valid;
      data_d  = wr_entry_i;
    end else if (ctrl_i.shift) begin
      valid_d = shift_entry_i.valid;
      data_d  = shift_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    entry_o       = data_q;
    entry_o.valid = valid_q;
  end

endmodule
`default_nettype wire

### hdl/rrdt_probe.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rrdt_probe
// Head-of-ring check: expiry of the entry and match against the reading.
// -----------------------------------------------------------------------------
module rrdt_probe (
  input  wire rrdt_pkg::entry_t                 entry_i,
  input  wire logic [rrdt_pkg::DeviceW-1:0]     device_i,
  input  wire logic [rrdt_pkg::CountW-1:0]      count_i,
  input  wire logic [rrdt_pkg::TimeW-1:0]       now_i,
  input  wire logic [rrdt_pkg::TtlW-1:0]        ttl_i,
  output rrdt_pkg::probe_t                      probe_o
);

  logic [rrdt_pkg::TimeW:0] age;
  logic                     expired;
  logic                     same;

  // top bit of the difference is the borrow: a stamp in the future never expires
  assign age     = {1'b0, now_i} - {1'b0, entry_i.stamp};
  assign expired = !age[rrdt_pkg::TimeW] &&
                   (age[rrdt_pkg::TimeW-1:0] >
                    {{(rrdt_pkg::TimeW-rrdt_pkg::TtlW){1'b0}}, ttl_i});
  assign same    = (entry_i.count == count_i) && (entry_i.device == device_i);

  assign probe_o.expire = entry_i.valid && expired;
  assign probe_o.hit    = entry_i.valid && !expired && same;

endmodule
`default_nettype wire

### hdl/recent_reading_dedup_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// recent_reading_dedup_table_core
// Duplicate suppression table of recent readings with a time-to-live.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries device_id, reading_counter
//   and current_time; output channel (out_valid_o / out_ready_i) carries
//   is_duplicate, one result per input transfer, in order.
//   The table is a ring of TABLE_ENTRIES cells. After a transfer the ring
//   rotates once per cycle through a full turn; the head cell is checked
//   for expiry and match, so entries are examined in index order. A finishing
//   step then writes the reading at the replace pointer when nothing matched
//   and loads the result register.
//   A new reading is taken only in the idle state, once the previous one has
//   passed the scan and finishing states, so the rotation of the ring sets
//   the pace.
//   A new reading is taken while a result waits; if the receiver stalls, the
//   finishing cycle of that reading holds until the result register is free.
//   Reset clears all valid bits and the replace pointer and loads
//   time_to_live with its default. time_to_live sits at APB address 0.
// -----------------------------------------------------------------------------
module recent_reading_dedup_table_core #(
  parameter int unsigned TABLE_ENTRIES = rrdt_pkg::TableEntriesDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // reading channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [rrdt_pkg::DeviceW-1:0]      device_id_i,
  input  wire logic [rrdt_pkg::CountW-1:0]       reading_counter_i,
  input  wire logic [rrdt_pkg::TimeW-1:0]        current_time_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   is_duplicate_o,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rrdt_pkg::ApbAddrW-1:0]     paddr,
  input  wire logic [rrdt_pkg::ApbDataW-1:0]     pwdata,
  output logic [rrdt_pkg::ApbDataW-1:0]          prdata,
  output logic                                   pready
);

  localparam int unsigned PtrW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [PtrW-1:0] LastIdx = PtrW'(TABLE_ENTRIES - 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  // configuration register
  logic [rrdt_pkg::TtlW-1:0] ttl_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rrdt_pkg::RegTimeToLive) ? ttl_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= rrdt_pkg::TtlReset;
    end else if (psel && penable && pwrite && (paddr[2] == rrdt_pkg::RegTimeToLive)) begin
      ttl_q <= pwdata;
    end
  end

  // control
  logic [1:0]      state_q, state_d;
  logic [PtrW-1:0] scan_q, scan_d;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic            found_q, found_d;
  logic            out_valid_q, out_valid_d;
  logic            dup_q, dup_d;

  logic [rrdt_pkg::DeviceW-1:0] dev_q;
  logic [rrdt_pkg::CountW-1:0]  cnt_q;
  logic [rrdt_pkg::TimeW-1:0]   now_q;

  logic             in_xfer;
  logic             finish_go;
  logic             do_write;
  rrdt_pkg::probe_t probe;

  rrdt_pkg::entry_t cell_q [TABLE_ENTRIES];
  rrdt_pkg::entry_t head_fb;
  rrdt_pkg::entry_t wr_entry;

  assign in_ready_o     = (state_q == StIdle);
  assign in_xfer        = in_valid_i && in_ready_o;
  assign out_valid_o    = out_valid_q;
  assign is_duplicate_o = dup_q;
  assign finish_go      = (state_q == StFinish) && (!out_valid_q || out_ready_i);
  assign do_write       = finish_go && !found_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      dev_q <= device_id_i;
      cnt_q <= reading_counter_i;
      now_q <= current_time_i;
    end
  end

  rrdt_probe u_probe (
    .entry_i  (cell_q[0]),
    .device_i (dev_q),
    .count_i  (cnt_q),
    .now_i    (now_q),
    .ttl_i    (ttl_q),
    .probe_o  (probe)
  );

  // drop expired entries as they leave the head, but not past a match
  always_comb begin
    head_fb       = cell_q[0];
    head_fb.valid = cell_q[0].valid && !(probe.expire && !found_q);
  end

  always_comb begin
    wr_entry.valid  = 1'b1;
    wr_entry.device = dev_q;
    wr_entry.count  = cnt_q;
    wr_entry.stamp  = now_q;
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    rrdt_pkg::cell_ctrl_t ctrl;
    rrdt_pkg::entry_t     shift_in;

    assign ctrl.shift = (state_q == StScan);
    assign ctrl.write = do_write && (ptr_q == PtrW'(k));

    if (k == TABLE_ENTRIES - 1) begin : g_tail
      assign shift_in = head_fb;
    end else begin : g_mid
      assign shift_in = cell_q[k+1];
    end

    rrdt_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .shift_entry_i (shift_in),
      .wr_entry_i    (wr_entry),
      .entry_o       (cell_q[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    ptr_d       = ptr_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    dup_d       = dup_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          state_d = StScan;
          scan_d  = '0;
          found_d = 1'b0;
        end
      end
      StScan: begin
        if (probe.hit) begin
          found_d = 1'b1;
        end
        if (scan_q == LastIdx) begin
          state_d = StFinish;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      StFinish: begin
        if (finish_go) begin
          out_valid_d = 1'b1;
          dup_d       = found_q;
          state_d     = StIdle;
          if (!found_q) begin
            ptr_d = (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scan_q      <= '0;
      ptr_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      ptr_q       <= ptr_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dup_q <= dup_d;
  end

endmodule
`default_nettype wire

### verif/tb_recent_reading_dedup_table_core.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_recent_reading_dedup_table_core
// Self-checking bench for the recent reading dedup table. A driver pushes
// readings from a queue and a monitor takes the duplicate flags back. Both
// sides idle at random. Every accepted reading goes through a table model in
// the bench, and the flag it predicts is compared with the returned one, in
// order. A directed set covers the expiry boundary, time running backwards,
// the stop at the first match, extreme field values and an ignored register
// address. Random phases then run under several time-to-live settings.
// -----------------------------------------------------------------------------
module tb_recent_reading_dedup_table_core;

  import rrdt_pkg::*;

  localparam int unsigned TableEntries = TableEntriesDefault;
  localparam int unsigned HalfPeriod   = 4;
  localparam int unsigned ItemsPerPhase = 305;
  localparam logic [ApbAddrW-1:0] TtlAddr   = {RegTimeToLive, 2'b00};
  localparam logic [ApbAddrW-1:0] SpareAddr = {~RegTimeToLive, 2'b00};
  localparam logic [TimeW-1:0]    TimeMax   = {TimeW{1'b1}};

  typedef struct {
    logic [DeviceW-1:0] device;
    logic [CountW-1:0]  count;
    logic [TimeW-1:0]   now;
  } reading_t;

  typedef struct {
    bit          dup;
    int unsigned seq;
  } verdict_t;

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                in_valid_i        = 1'b0;
  logic                in_ready_o;
  logic [DeviceW-1:0]  device_id_i       = '0;
  logic [CountW-1:0]   reading_counter_i = '0;
  logic [TimeW-1:0]    current_time_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i       = 1'b0;
  logic                is_duplicate_o;
  logic                psel              = 1'b0;
  logic                penable           = 1'b0;
  logic                pwrite            = 1'b0;
  logic [ApbAddrW-1:0] paddr             = '0;
  logic [ApbDataW-1:0] pwdata            = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // table model
  bit                 tab_live   [TableEntries];
  logic [DeviceW-1:0] tab_device [TableEntries];
  logic [CountW-1:0]  tab_count  [TableEntries];
  logic [TimeW-1:0]   tab_stamp  [TableEntries];
  int unsigned        next_slot;
  logic [TtlW-1:0]    ttl_model;

  reading_t    pending_readings[$];
  verdict_t    expected_verdicts[$];
  int unsigned readings_queued  = 0;
  int unsigned readings_sent    = 0;
  int unsigned results_seen     = 0;
  int unsigned duplicates_seen  = 0;
  int unsigned ttl_settings     = 1;
  int unsigned errors           = 0;
  int unsigned send_gap         = 0;
  int unsigned recv_stall       = 0;
  bit          send_quiet       = 1'b0;
  bit          recv_quiet       = 1'b0;
  reading_t    next_reading;
  verdict_t    new_verdict;

  recent_reading_dedup_table_core #(
    .TABLE_ENTRIES(TableEntries)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .device_id_i(device_id_i),
    .reading_counter_i(reading_counter_i),
    .current_time_i(current_time_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .is_duplicate_o(is_duplicate_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk_i = 1'b0;
    #(HalfPeriod);
    clk_i = 1'b1;
    #(HalfPeriod);
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    errors++;
  endtask

  // Scan in index order, dropping expired entries, stop at the first live match.
  function automatic bit predict_duplicate(input logic [DeviceW-1:0] dev,
                                           input logic [CountW-1:0] cnt,
                                           input logic [TimeW-1:0] now);
    bit               hit;
    logic [TimeW-1:0] ttl_wide;
    hit      = 1'b0;
    ttl_wide = {{(TimeW-TtlW){1'b0}}, ttl_model};
    for (int i = 0; i < TableEntries && !hit; i++) begin
      if (tab_live[i]) begin
        if (now >= tab_stamp[i] && (now - tab_stamp[i]) > ttl_wide) begin
          tab_live[i] = 1'b0;
        end else if (tab_count[i] == cnt && tab_device[i] == dev) begin
          hit = 1'b1;
        end
      end
    end
    if (!hit) begin
      tab_live[next_slot]   = 1'b1;
      tab_device[next_slot] = dev;
      tab_count[next_slot]  = cnt;
      tab_stamp[next_slot]  = now;
      next_slot = (next_slot + 1) % TableEntries;
    end
    return hit;
  endfunction

  function automatic logic [63:0] rand_word64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  // driver: one reading per transfer, random gap before the next
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        new_verdict.dup = predict_duplicate(device_id_i, reading_counter_i, current_time_i);
        new_verdict.seq = readings_sent;
        expected_verdicts.push_back(new_verdict);
        readings_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_readings.size() > 0) begin
          next_reading = pending_readings.pop_front();
          device_id_i       <= next_reading.device;
          reading_counter_i <= next_reading.count;
          current_time_i    <= next_reading.now;
          in_valid_i        <= 1'b1;
          if ($urandom_range(0, 63) == 0) send_quiet = ~send_quiet;
          send_gap = draw_wait(send_quiet);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: take results, stall at random, compare with the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (is_duplicate_o === 1'b1) duplicates_seen++;
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          new_verdict = expected_verdicts.pop_front();
          if (is_duplicate_o !== new_verdict.dup) begin
            report_mismatch($sformatf("reading %0d: is_duplicate %b, predicted %b",
                                      new_verdict.seq, is_duplicate_o, new_verdict.dup));
          end
        end
        if ($urandom_range(0, 63) == 0) recv_quiet = ~recv_quiet;
        recv_stall = draw_wait(recv_quiet);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic queue_reading(input logic [DeviceW-1:0] dev, input logic [CountW-1:0] cnt,
                               input logic [TimeW-1:0] now);
    reading_t rd;
    rd.device = dev;
    rd.count  = cnt;
    rd.now    = now;
    pending_readings.push_back(rd);
    readings_queued++;
  endtask

  // hold until every queued reading has returned its flag
  task automatic settle();
    while (results_seen < readings_queued) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == TtlAddr) ttl_model = data;
  endtask

  task automatic apb_read_check(input logic [ApbAddrW-1:0] addr,
                                input logic [ApbDataW-1:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      report_mismatch($sformatf("register read at %0d: %h, expected %h", addr, prdata, want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly readings from a small pool of devices and counters with time moving
  // in steps scaled to the time-to-live, so matches and expiries are frequent.
  task automatic run_ttl_phase(input logic [TtlW-1:0] ttl_val, input logic [TimeW-1:0] start,
                               input int unsigned n_items);
    logic [DeviceW-1:0] dev_pool[6];
    logic [CountW-1:0]  cnt_base;
    logic [TimeW-1:0]   cur_time;
    logic [TimeW-1:0]   now;
    logic [DeviceW-1:0] last_dev;
    logic [CountW-1:0]  last_cnt;
    logic [TimeW-1:0]   last_now;
    int unsigned        step_max;
    int unsigned        pick;
    apb_write(TtlAddr, ttl_val);
    apb_read_check(TtlAddr, ttl_val);
    ttl_settings++;
    foreach (dev_pool[k]) dev_pool[k] = rand_word64();
    if ($urandom_range(0, 1)) dev_pool[0] = '0;
    if ($urandom_range(0, 1)) dev_pool[1] = '1;
    cnt_base = $urandom;
    step_max = ttl_val / 8 + 2;
    cur_time = start;
    last_dev = dev_pool[0];
    last_cnt = cnt_base;
    last_now = cur_time;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        queue_reading(rand_word64(), $urandom, rand_word64());
      end else if (pick < 12) begin
        // revisit the last reading right at or just past its expiry
        cur_time = last_now + ttl_val + $urandom_range(0, 1);
        queue_reading(last_dev, last_cnt, cur_time);
      end else if (pick < 17) begin
        now = cur_time - $urandom_range(0, step_max);
        queue_reading(dev_pool[$urandom_range(0, 5)], cnt_base + $urandom_range(0, 3), now);
      end else begin
        cur_time = cur_time + $urandom_range(0, step_max);
        last_dev = dev_pool[$urandom_range(0, 5)];
        last_cnt = cnt_base + $urandom_range(0, 3);
        last_now = cur_time;
        queue_reading(last_dev, last_cnt, cur_time);
      end
    end
    settle();
  endtask

  initial begin
    logic [DeviceW-1:0] dev_x;
    logic [DeviceW-1:0] dev_y;
    logic [DeviceW-1:0] dev_z;
    logic [TimeW-1:0]   ttl_t;
    foreach (tab_live[k]) tab_live[k] = 1'b0;
    next_slot = 0;
    ttl_model = TtlReset;
    ttl_t = {{(TimeW-TtlW){1'b0}}, TtlReset};
    dev_x = 64'h0123_4567_89AB_CDEF;
    dev_y = 64'hFEDC_BA98_7654_3210;
    dev_z = rand_word64();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    apb_read_check(TtlAddr, TtlReset);

    // directed readings under the reset time-to-live
    queue_reading('0, '0, '0);
    queue_reading('0, '0, '0);
    queue_reading('1, '1, ttl_t);
    queue_reading('1, '1, '0);             // time behind the stamp: still live
    queue_reading('0, '0, ttl_t);          // age equal to the limit: not expired
    queue_reading('0, '0, ttl_t + 1);      // one past the limit: expired
    queue_reading(dev_x, 32'd5, 63'd1000);
    queue_reading(dev_y, 32'd6, 63'd0);
    queue_reading(dev_x, 32'd5, ttl_t + 500);  // match stops the scan before dev_y
    queue_reading(dev_y, 32'd6, 63'd100);      // so dev_y was left valid
    queue_reading(dev_y, 32'd6, ttl_t + 501);
    queue_reading(dev_x, 32'd5, TimeMax);
    queue_reading(dev_x, 32'd5, '0);
    queue_reading('1, '0, TimeMax);
    queue_reading('0, '1, TimeMax - 1);
    settle();

    // a write to an unused address must leave the time-to-live alone
    apb_write(SpareAddr, '0);
    apb_read_check(TtlAddr, TtlReset);
    queue_reading(dev_z, 32'd7, 63'd1000);
    queue_reading(dev_z, 32'd7, 63'd1001);
    queue_reading(dev_z, 32'd7, 63'd1001 + ttl_t);
    settle();

    run_ttl_phase('0, rand_word64(), ItemsPerPhase);
    run_ttl_phase(32'd1, rand_word64(), ItemsPerPhase);
    run_ttl_phase(32'd1000, rand_word64(), ItemsPerPhase);
    run_ttl_phase('1, TimeMax - 64'd4_000_000_000, ItemsPerPhase);
    run_ttl_phase($urandom, rand_word64(), ItemsPerPhase);
    run_ttl_phase(TtlReset, rand_word64(), ItemsPerPhase);

    repeat (2 * TableEntries + 8) @(posedge clk_i);
    if (expected_verdicts.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_verdicts.size()));
    end
    $display("Covered %0d readings, %0d flagged duplicate, under %0d time-to-live settings",
             readings_sent, duplicates_seen, ttl_settings);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Timeout: %0d of %0d results received", results_seen, readings_queued);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
